@@ rtl/trpe_pkg.sv @@
`timescale 1ns / 1ps

package trpe_pkg;

  // time stamps, durations and the accumulator share one fixed-point width
  localparam int unsigned TIME_W = 32;

  // saturating drop counter width
  localparam int unsigned DROP_W = 16;

  // configuration data and address widths
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_EMISSION_DELAY = 1'b0,
    REG_ENTRY_LIFETIME = 1'b1
  } reg_idx_e;

  // register reset values (one second with 16 fraction bits)
  localparam logic [TIME_W-1:0] EMISSION_DELAY_RST = 32'h0001_0000;
  localparam logic [TIME_W-1:0] ENTRY_LIFETIME_RST = 32'h0001_0000;

endpackage

@@ rtl/timed_ring_pool_emitter_core.sv @@
`timescale 1ns / 1ps

// Timed ring pool emitter. A tick word (elapsed_time_i, now_time_i) is taken
// when start is high and busy is low; exactly one result word follows,
// shown for one cycle with done_o high, and the receiver cannot stall it.
// A tick first retires expired entries from the head of the ring, one
// entry per cycle out of the emit time memory, while a serial divider
// works out the number of emissions in parallel; then it writes one new
// entry per cycle at the tail. A tick runs through the states retire,
// wait for the divider, emit and done; the core takes no new tick until
// the result of the last one has been shown, as busy stays high until then.
// Configuration may be written over the APB port only while busy is low.
module timed_ring_pool_emitter_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [trpe_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [trpe_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [trpe_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // tick command
  input  logic                                   start,
  output logic                                   busy,
  input  logic [trpe_pkg::TIME_W-1:0]            elapsed_time_i,
  input  logic [trpe_pkg::TIME_W-1:0]            now_time_i,
  // result word
  output logic                                   done_o,
  output logic [$clog2(CAPACITY+1)-1:0]          live_count_o,
  output logic [$clog2(CAPACITY)-1:0]            oldest_index_o,
  output logic [$clog2(CAPACITY)-1:0]            next_free_index_o,
  output logic [$clog2(CAPACITY+1)-1:0]          retired_count_o,
  output logic [$clog2(CAPACITY+1)-1:0]          emitted_count_o,
  output logic [trpe_pkg::DROP_W-1:0]            dropped_saturated_o
);

  import trpe_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_RETIRE   = 5'b00010,
    ST_WAIT_DIV = 5'b00100,
    ST_EMIT     = 5'b01000,
    ST_DONE     = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [TIME_W-1:0] delay_q, lifetime_q;
  logic [PW-1:0]     head_q, head_d, tail_q;
  logic [CW-1:0]     alive_q, retired_q, emit_cnt_q, emit_target_q;
  logic [TIME_W-1:0] acc_q, acc_sat_q;
  logic              need_div_q;
  logic [TIME_W-1:0] now_q;
  logic [DROP_W-1:0] drop_q;

  logic              accept;
  logic              cfg_wr;
  logic [TIME_W:0]   acc_sum;
  logic [TIME_W-1:0] acc_sat;
  logic [TIME_W-1:0] delay_eff;
  logic              div_busy;
  logic [TIME_W-1:0] div_quo, div_rem;
  logic [TIME_W-1:0] rd_time;
  logic [TIME_W-1:0] age;
  logic              retire_go;
  logic              emit_go;
  logic [TIME_W-1:0] wanted;
  logic [TIME_W-1:0] free_slots;
  logic [CW-1:0]     target;
  logic [TIME_W-1:0] drops;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= EMISSION_DELAY_RST;
      lifetime_q <= ENTRY_LIFETIME_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_EMISSION_DELAY: delay_q    <= pwdata;
        REG_ENTRY_LIFETIME: lifetime_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_EMISSION_DELAY: prdata = delay_q;
      REG_ENTRY_LIFETIME: prdata = lifetime_q;
      default:            prdata = '0;
    endcase
  end

  // saturating accumulate and emission divide
  assign acc_sum   = {1'b0, acc_q} + {1'b0, elapsed_time_i};
  assign acc_sat   = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
  assign delay_eff = (delay_q == '0) ? TIME_W'(1) : delay_q;

  trpe_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .dividend_i  (acc_sat - TIME_W'(1)),
    .divisor_i   (delay_eff),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // emit time memory, read address follows the next head
  trpe_ram #(
    .WIDTH (TIME_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (emit_go),
    .waddr_i (tail_q),
    .wdata_i (now_q),
    .raddr_i (head_d),
    .rdata_o (rd_time)
  );

  // retire check on the head entry read in the previous cycle
  assign age       = now_q - rd_time;
  assign retire_go = (state_q == ST_RETIRE) && (alive_q != '0) && (age >= lifetime_q);
  assign emit_go   = (state_q == ST_EMIT) && (emit_cnt_q != emit_target_q);

  always_comb begin
    head_d = head_q;
    if (retire_go) begin
      head_d = (head_q == PW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
    end
  end

  // emission count limited by free slots, the rest are drops
  assign wanted     = need_div_q ? div_quo : '0;
  assign free_slots = TIME_W'(CAPACITY) - TIME_W'(alive_q);
  assign target     = (wanted < free_slots) ? CW'(wanted) : CW'(free_slots);
  assign drops      = wanted - TIME_W'(target);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = ST_RETIRE;
      ST_RETIRE:   if (!retire_go) state_d = ST_WAIT_DIV;
      ST_WAIT_DIV: if (!div_busy) state_d = ST_EMIT;
      ST_EMIT:     if (!emit_go) state_d = ST_DONE;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      alive_q       <= '0;
      acc_q         <= '0;
      retired_q     <= '0;
      emit_cnt_q    <= '0;
      emit_target_q <= '0;
      need_div_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (accept) begin
        retired_q  <= '0;
        emit_cnt_q <= '0;
        need_div_q <= (acc_sat > delay_eff);
      end
      if (retire_go) begin
        alive_q   <= alive_q - 1'b1;
        retired_q <= retired_q + 1'b1;
      end
      // divider finished: settle accumulator and emission target
      if (state_q == ST_WAIT_DIV && !div_busy) begin
        emit_target_q <= target;
        acc_q         <= need_div_q ? div_rem + TIME_W'(1) : acc_sat_q;
      end
      if (emit_go) begin
        tail_q     <= (tail_q == PW'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;
        alive_q    <= alive_q + 1'b1;
        emit_cnt_q <= emit_cnt_q + 1'b1;
      end
    end
  end

  // tick payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q     <= now_time_i;
      acc_sat_q <= acc_sat;
    end
    if (state_q == ST_WAIT_DIV && !div_busy) begin
      drop_q <= (drops > TIME_W'({DROP_W{1'b1}})) ? '1 : drops[DROP_W-1:0];
    end
  end

  // result word
  assign done_o              = (state_q == ST_DONE);
  assign live_count_o        = alive_q;
  assign oldest_index_o      = head_q;
  assign next_free_index_o   = tail_q;
  assign retired_count_o     = retired_q;
  assign emitted_count_o     = emit_cnt_q;
  assign dropped_saturated_o = drop_q;

  // a write never lands on a full ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> alive_q < CW'(CAPACITY))
    else $error("write into full ring");

  // live count stays within capacity and emission is finished at every result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (alive_q <= CW'(CAPACITY)) && (emit_cnt_q == emit_target_q))
    else $error("result with bad live count or unfinished emission");

  // an empty ring ends the retire walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RETIRE && alive_q == '0) |=> state_q == ST_WAIT_DIV)
    else $error("retire walk past empty ring");

  // the divider is running once the retire walk starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> div_busy && state_q == ST_RETIRE)
    else $error("divider not started with tick");

  // no entry is both written and retired in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit_go && retire_go))
    else $error("retire and emit overlap");

endmodule

@@ rtl/trpe_ram.sv @@
`timescale 1ns / 1ps

module trpe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/trpe_div.sv @@
`timescale 1ns / 1ps

module trpe_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [trpe_pkg::TIME_W-1:0] dividend_i,
  input  logic [trpe_pkg::TIME_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic [trpe_pkg::TIME_W-1:0] quotient_o,
  output logic [trpe_pkg::TIME_W-1:0] remainder_o
);

  import trpe_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_W);

  logic              busy_q;
  logic [CNT_W-1:0]  count_q;
  logic [TIME_W-1:0] quo_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] dsr_q;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              take;

  // restoring step: shift in the next dividend bit and try the subtract
  assign shifted = {rem_q, quo_q[TIME_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign take    = ~diff[TIME_W];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      count_q <= '0;
    end else if (busy_q) begin
      count_q <= count_q + 1'b1;
      if (count_q == CNT_W'(TIME_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TIME_W-2:0], take};
      rem_q <= take ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ bench/tb_timed_ring_pool_emitter_core.sv @@
`timescale 1ns / 1ps

module tb_timed_ring_pool_emitter_core;
  import trpe_pkg::*;

  localparam int unsigned CAP   = 1024;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned IDX_W = $clog2(CAP);

  // one result word, field by field
  typedef struct packed {
    logic [CNT_W-1:0]  live_count;
    logic [IDX_W-1:0]  oldest_index;
    logic [IDX_W-1:0]  next_free_index;
    logic [CNT_W-1:0]  retired_count;
    logic [CNT_W-1:0]  emitted_count;
    logic [DROP_W-1:0] dropped_saturated;
  } tick_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start;
  logic                  busy;
  logic [TIME_W-1:0]     elapsed_time_i;
  logic [TIME_W-1:0]     now_time_i;
  logic                  done_o;
  logic [CNT_W-1:0]      live_count_o;
  logic [IDX_W-1:0]      oldest_index_o;
  logic [IDX_W-1:0]      next_free_index_o;
  logic [CNT_W-1:0]      retired_count_o;
  logic [CNT_W-1:0]      emitted_count_o;
  logic [DROP_W-1:0]     dropped_saturated_o;

  // shadow of the ring and of the registers
  logic [TIME_W-1:0] emit_times [CAP];
  logic [IDX_W-1:0]  ring_head;
  logic [IDX_W-1:0]  ring_tail;
  int unsigned       alive_entries;
  logic [TIME_W-1:0] emit_acc;
  logic [TIME_W-1:0] cfg_delay;
  logic [TIME_W-1:0] cfg_lifetime;

  tick_result_t pending_results [$];
  tick_result_t oldest_result;

  int unsigned       sender_idle_pct;
  logic [TIME_W-1:0] flow_clock;
  int unsigned       error_count;
  int unsigned       ticks_sent;
  int unsigned       results_checked;
  int unsigned       reg_writes;
  int unsigned       peak_live;
  int unsigned       drop_ticks;
  int unsigned       total_retired;

  timed_ring_pool_emitter_core #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .start              (start),
    .busy               (busy),
    .elapsed_time_i     (elapsed_time_i),
    .now_time_i         (now_time_i),
    .done_o             (done_o),
    .live_count_o       (live_count_o),
    .oldest_index_o     (oldest_index_o),
    .next_free_index_o  (next_free_index_o),
    .retired_count_o    (retired_count_o),
    .emitted_count_o    (emitted_count_o),
    .dropped_saturated_o(dropped_saturated_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // expected outcome of one tick, advancing the shadow ring
  function automatic tick_result_t predict_tick(input logic [TIME_W-1:0] dt,
                                                input logic [TIME_W-1:0] stamp);
    tick_result_t      res;
    logic [TIME_W-1:0] eff_delay;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] wanted;
    logic [TIME_W:0]   sum;
    int unsigned       retired;
    int unsigned       emitted;
    int unsigned       free_slots;
    int unsigned       dropped;
    int unsigned       k;
    logic              young;
    eff_delay = (cfg_delay == '0) ? 32'd1 : cfg_delay;
    retired   = 0;
    young     = 1'b0;
    // retire from the head until the first young entry
    while (alive_entries != 0 && !young) begin
      age = stamp - emit_times[ring_head];
      if (age < cfg_lifetime) begin
        young = 1'b1;
      end else begin
        ring_head     = ring_head + 1'b1;  // capacity is a power of two
        alive_entries = alive_entries - 1;
        retired       = retired + 1;
      end
    end
    // saturating accumulate
    sum      = {1'b0, emit_acc} + {1'b0, dt};
    emit_acc = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    // emissions the subtract loop would make
    wanted = '0;
    if (emit_acc > eff_delay) begin
      wanted   = (emit_acc - 1) / eff_delay;
      emit_acc = emit_acc - wanted * eff_delay;
    end
    free_slots = CAP - alive_entries;
    emitted    = (wanted < free_slots) ? wanted : free_slots;
    for (k = 0; k < emitted; k++) begin
      emit_times[ring_tail] = stamp;
      ring_tail             = ring_tail + 1'b1;
    end
    alive_entries = alive_entries + emitted;
    dropped       = wanted - emitted;
    if (dropped > 65535) begin
      dropped = 65535;
    end
    res.live_count        = CNT_W'(alive_entries);
    res.oldest_index      = ring_head;
    res.next_free_index   = ring_tail;
    res.retired_count     = CNT_W'(retired);
    res.emitted_count     = CNT_W'(emitted);
    res.dropped_saturated = DROP_W'(dropped);
    return res;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      error_count++;
    end
  endtask

  // compare each result word with the oldest outstanding expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result word with no tick outstanding, expected none, got live %0d",
                 $time, live_count_o);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("live_count", oldest_result.live_count, live_count_o);
        check_field("oldest_index", oldest_result.oldest_index, oldest_index_o);
        check_field("next_free_index", oldest_result.next_free_index, next_free_index_o);
        check_field("retired_count", oldest_result.retired_count, retired_count_o);
        check_field("emitted_count", oldest_result.emitted_count, emitted_count_o);
        check_field("dropped_saturated", oldest_result.dropped_saturated,
                    dropped_saturated_o);
        results_checked++;
      end
    end
  end

  // send one tick word; entered and left at a falling edge, start left high
  task automatic send_tick(input logic [TIME_W-1:0] dt, input logic [TIME_W-1:0] stamp);
    tick_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start          = 1'b1;
    elapsed_time_i = dt;
    now_time_i     = stamp;
    do @(posedge clk_i); while (busy);
    res = predict_tick(dt, stamp);
    pending_results.push_back(res);
    ticks_sent++;
    total_retired += res.retired_count;
    if (res.live_count > peak_live) begin
      peak_live = res.live_count;
    end
    if (res.dropped_saturated != 0) begin
      drop_ticks++;
    end
    @(negedge clk_i);
  endtask

  // hold off until every outstanding result word has come back
  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0 || busy) begin
      @(negedge clk_i);
    end
  endtask

  // register write while idle, then read it back
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    drain_results();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    case (idx)
      REG_EMISSION_DELAY: cfg_delay    = value;
      REG_ENTRY_LIFETIME: cfg_lifetime = value;
      default: ;
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== value) begin
      $display("%0t ns: register %s readback mismatch, expected %0h, got %0h",
               $time, idx.name(), value, readback);
      error_count++;
    end
    reg_writes++;
  endtask

  // random ticks: mostly a clock advancing by dt, some noise and jumps
  task automatic run_flow(input int unsigned count, input int unsigned idle_pct,
                          input logic [TIME_W-1:0] dt_lo, input logic [TIME_W-1:0] dt_hi,
                          input int unsigned noise_pct);
    logic [TIME_W-1:0] dt;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      if ($urandom_range(99) < noise_pct) begin
        dt = $urandom >> $urandom_range(31, 0);
        if ($urandom_range(1) == 1) begin
          flow_clock = $urandom;
        end else begin
          flow_clock = flow_clock - $urandom_range(32'h0002_0000);
        end
      end else begin
        dt         = $urandom_range(dt_hi, dt_lo);
        flow_clock = flow_clock + dt;
      end
      send_tick(dt, flow_clock);
    end
  endtask

  // reset settings, first emission and first retirement
  task automatic test_reset_values();
    sender_idle_pct = 0;
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h0001_0000, 32'h0001_0000);
    send_tick(32'h0000_0001, 32'h0001_0001);
    send_tick(32'h0002_0000, 32'h0003_0001);
  endtask

  // accumulator pinned at the top, equal to the largest delay
  task automatic test_accumulator_saturation();
    write_reg(REG_EMISSION_DELAY, 32'hFFFF_FFFF);
    write_reg(REG_ENTRY_LIFETIME, 32'hFFFF_FFFF);
    sender_idle_pct = 0;
    send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // zero delay from a full accumulator: fills the ring, drops saturate
  task automatic test_burst_emission();
    write_reg(REG_EMISSION_DELAY, 32'h0000_0000);
    write_reg(REG_ENTRY_LIFETIME, 32'h0000_0000);
    sender_idle_pct = 0;
    send_tick(32'h0000_0000, 32'h1234_5678);
    send_tick(32'h0000_0005, 32'h1234_5679);
    write_reg(REG_EMISSION_DELAY, 32'h0000_0001);
    send_tick(32'h0000_0002, 32'h1234_567A);
  endtask

  // entry age taken across the wrap of the time stamp
  task automatic test_time_wrap();
    write_reg(REG_EMISSION_DELAY, 32'h0001_0000);
    write_reg(REG_ENTRY_LIFETIME, 32'h0000_8000);
    sender_idle_pct = 0;
    send_tick(32'h0001_0001, 32'hFFFF_F000);
    send_tick(32'h0000_0000, 32'h0000_3000);
    send_tick(32'h0001_0000, 32'h0000_7000);
  endtask

  // about one and a half emissions per tick, no idling
  task automatic test_steady_flow();
    write_reg(REG_EMISSION_DELAY, 32'h0001_0000);
    write_reg(REG_ENTRY_LIFETIME, 32'h0004_0000);
    flow_clock = 32'h0010_0000;
    run_flow(50, 0, 32'h0000_0000, 32'h0003_0000, 0);
  endtask

  // hundreds of emissions per tick against a long lifetime: ring stays full
  task automatic test_full_ring();
    write_reg(REG_EMISSION_DELAY, 32'h0000_0100);
    write_reg(REG_ENTRY_LIFETIME, 32'h0008_0000);
    run_flow(40, 72, 32'h0000_8000, 32'h0001_8000, 5);
    drain_results();
    run_flow(30, 23, 32'h0000_8000, 32'h0001_8000, 5);
  endtask

  // clock runs through its wrap point
  task automatic test_clock_wrap();
    write_reg(REG_EMISSION_DELAY, 32'h0000_3000);
    write_reg(REG_ENTRY_LIFETIME, 32'h0002_0000);
    flow_clock = 32'hFFF0_0000;
    run_flow(60, 23, 32'h0000_0000, 32'h0001_0000, 10);
  endtask

  // random register settings with heavy noise
  task automatic test_random_settings();
    repeat (2) begin
      write_reg(REG_EMISSION_DELAY, $urandom >> $urandom_range(28, 4));
      write_reg(REG_ENTRY_LIFETIME, $urandom >> $urandom_range(28, 0));
      run_flow(25, 72, 32'h0000_0000, 32'h0004_0000, 30);
    end
  endtask

  // smallest delay, very short lifetime
  task automatic test_fine_grain();
    write_reg(REG_EMISSION_DELAY, 32'h0000_0001);
    write_reg(REG_ENTRY_LIFETIME, 32'h0000_0040);
    run_flow(48, 0, 32'h0000_0000, 32'h0000_0080, 10);
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    start           = 1'b0;
    elapsed_time_i  = '0;
    now_time_i      = '0;
    ring_head       = '0;
    ring_tail       = '0;
    alive_entries   = 0;
    emit_acc        = '0;
    cfg_delay       = EMISSION_DELAY_RST;
    cfg_lifetime    = ENTRY_LIFETIME_RST;
    sender_idle_pct = 0;
    flow_clock      = '0;
    error_count     = 0;
    ticks_sent      = 0;
    results_checked = 0;
    reg_writes      = 0;
    peak_live       = 0;
    drop_ticks      = 0;
    total_retired   = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_accumulator_saturation();
    test_burst_emission();
    test_time_wrap();
    test_steady_flow();
    test_full_ring();
    test_clock_wrap();
    test_random_settings();
    test_fine_grain();

    // let the last result word land, then watch for strays
    drain_results();
    repeat (50) @(negedge clk_i);

    $display("covered %0d tick words and %0d register writes, %0d result words checked",
             ticks_sent, reg_writes, results_checked);
    $display("ring peaked at %0d live entries, %0d ticks dropped emissions, %0d retirements",
             peak_live, drop_ticks, total_retired);
    if (error_count == 0) begin
      $display("tb_timed_ring_pool_emitter_core passed");
    end else begin
      $display("tb_timed_ring_pool_emitter_core failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("timeout: %0d result words still outstanding", pending_results.size());
    $display("tb_timed_ring_pool_emitter_core failed");
    $finish;
  end

endmodule
